FILE: design/cad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cad_pkg
// Types, codes and per-mode code layout for the ADPCM byte decoder.
// ----------------------------------------------------------------------------
package cad_pkg;

    typedef enum logic [1:0] {
        MODE_4BIT = 2'd0,
        MODE_3BIT = 2'd1,
        MODE_2BIT = 2'd2,
        MODE_RSVD = 2'd3
    } mode_t;

    localparam logic CMD_REF  = 1'b0;
    localparam logic CMD_CODE = 1'b1;

    typedef struct packed {
        logic       sign;
        logic [2:0] mag;
    } code_t;

    // code idx of a packed byte, most significant code first
    function automatic code_t get_code(mode_t mode, logic [1:0] idx, logic [7:0] b);
        code_t c;
        c = '0;
        unique case (mode)
            MODE_3BIT:
            begin
                unique case (idx)
                    2'd0:    c = '{sign: b[7], mag: {1'b0, b[6:5]}};
                    2'd1:    c = '{sign: b[4], mag: {1'b0, b[3:2]}};
                    default: c = '{sign: b[1], mag: {2'b00, b[0]}};
                endcase
            end
            MODE_2BIT:
            begin
                unique case (idx)
                    2'd0:    c = '{sign: b[7], mag: {2'b00, b[6]}};
                    2'd1:    c = '{sign: b[5], mag: {2'b00, b[4]}};
                    2'd2:    c = '{sign: b[3], mag: {2'b00, b[2]}};
                    default: c = '{sign: b[1], mag: {2'b00, b[0]}};
                endcase
            end
            MODE_4BIT, MODE_RSVD:
            begin
                if (idx[0] == 1'b0)
                    c = '{sign: b[7], mag: b[6:4]};
                else
                    c = '{sign: b[3], mag: b[2:0]};
            end
        endcase
        return c;
    endfunction

    function automatic logic [1:0] last_idx(mode_t mode);
        logic [1:0] r;
        unique case (mode)
            MODE_3BIT:            r = 2'd2;
            MODE_2BIT:            r = 2'd3;
            MODE_4BIT, MODE_RSVD: r = 2'd1;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] step_limit(mode_t mode);
        logic [2:0] r;
        unique case (mode)
            MODE_3BIT:            r = 3'd3;
            MODE_2BIT:            r = 3'd1;
            MODE_4BIT, MODE_RSVD: r = 3'd5;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] step_floor(mode_t mode);
        logic [2:0] r;
        unique case (mode)
            MODE_2BIT:                       r = 3'd2;
            MODE_4BIT, MODE_3BIT, MODE_RSVD: r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: design/cad_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cad_in_if
// Byte request channel: reference or code byte with valid/ready.
// ----------------------------------------------------------------------------
interface cad_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] data_byte;

    modport source (output valid, output cmd, output data_byte, input ready);
    modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

FILE: design/cad_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cad_out_if
// Sample request channel: decoded sample and last flag with valid/ready.
// ----------------------------------------------------------------------------
interface cad_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] sample;
    logic       last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

FILE: design/creative_adpcm_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// creative_adpcm_decoder
// Decodes 4-bit, 3-bit and 2-bit packed ADPCM bytes into unsigned 8-bit samples.
// ----------------------------------------------------------------------------
//  channel       dir   payload              request
//  byte_chan     in    cmd, data_byte       one reference or code byte
//  sample_chan   out   sample, last         one decoded sample
//  cfg           in    cfg_wr_data[1:0]     code_mode write
//
//  A code byte yields 2, 3 or 4 samples, one per cycle unless the output stalls,
//  from one shared add/saturate/adapt path; the next byte is taken in the cycle
//  of the last code. A reference byte yields no sample.
//  Reset: predictor 128, step 0, mode 0. Output stalls hold the code sequencer.
// ----------------------------------------------------------------------------
module creative_adpcm_decoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data,
    cad_in_if.sink     byte_chan,
    cad_out_if.source  sample_chan
);
    import cad_pkg::*;

    mode_t             mode_reg;
    logic              busy_reg;
    logic [1:0]        idx_reg;
    logic [7:0]        byte_reg;
    logic [7:0]        pred_reg;
    logic [2:0]        step_reg;
    logic              out_valid_reg;
    logic [7:0]        sample_reg;
    logic              last_reg;

    code_t             code;
    logic              is_last;
    logic              advance;
    logic              accept;
    logic [9:0]        delta;
    logic signed [11:0] sum;
    logic [7:0]        pred_next;
    logic [2:0]        step_next;
    logic [2:0]        floor_m;

    always_comb
    begin
        code    = get_code(mode_reg, idx_reg, byte_reg);
        is_last = (idx_reg == last_idx(mode_reg));
        advance = busy_reg && (!out_valid_reg || sample_chan.ready);
        floor_m = step_floor(mode_reg);
        delta   = 10'(code.mag) << step_reg;
        if (code.sign)
            sum = $signed({4'b0, pred_reg}) - $signed({2'b0, delta});
        else
            sum = $signed({4'b0, pred_reg}) + $signed({2'b0, delta});
        priority if (sum < 0)
            pred_next = 8'd0;
        else if (sum > 12'sd255)
            pred_next = 8'd255;
        else
            pred_next = sum[7:0];
        step_next = step_reg;
        if (code.mag >= step_limit(mode_reg) && step_reg < floor_m + 3'd3)
            step_next = step_reg + 3'd1;
        if (code.mag == 3'd0 && step_reg > floor_m)
            step_next = step_reg - 3'd1;
    end

    assign byte_chan.ready   = !busy_reg || (advance && is_last);
    assign accept            = byte_chan.valid && byte_chan.ready;
    assign sample_chan.valid = out_valid_reg;
    assign sample_chan.sample = sample_reg;
    assign sample_chan.last  = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_4BIT;
            busy_reg      <= 1'b0;
            idx_reg       <= 2'd0;
            pred_reg      <= 8'd128;
            step_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                mode_reg <= mode_t'(cfg_wr_data);

            if (advance)
                out_valid_reg <= 1'b1;
            else if (sample_chan.ready)
                out_valid_reg <= 1'b0;

            if (accept && byte_chan.cmd == CMD_REF)
            begin
                pred_reg <= byte_chan.data_byte;
                step_reg <= floor_m;
            end
            else if (advance)
            begin
                pred_reg <= pred_next;
                step_reg <= step_next;
            end

            if (accept)
            begin
                busy_reg <= (byte_chan.cmd == CMD_CODE);
                idx_reg  <= 2'd0;
            end
            else if (advance)
            begin
                if (is_last)
                    busy_reg <= 1'b0;
                else
                    idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            byte_reg <= byte_chan.data_byte;
        if (advance)
        begin
            sample_reg <= pred_next;
            last_reg   <= is_last;
        end
    end

    // assertions
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= 3'd5)
        else $error("step out of range");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> idx_reg <= last_idx(mode_reg))
        else $error("code index past last code");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && out_valid_reg && !sample_chan.ready |=> $stable(idx_reg))
        else $error("sequencer moved during output stall");

    a_code_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && byte_chan.cmd == CMD_CODE |=> busy_reg && idx_reg == 2'd0)
        else $error("code byte not started");

    a_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && byte_chan.ready |-> advance && is_last)
        else $error("byte taken while codes remain");

endmodule

FILE: dv/cad_sample_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cad_sample_checker
// Watches the byte and sample channels and the mode register writes of the
// ADPCM decoder. Keeps its own predictor, step and mode, queues the samples
// each accepted code byte must produce, and compares every accepted sample
// request with the oldest queued one.
// ----------------------------------------------------------------------------
module cad_sample_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic       in_cmd,
    input  logic [7:0] in_byte,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] out_pcm,
    input  logic       out_last,
    output int         fail_count,
    output int         pending
);
    import cad_pkg::*;

    typedef struct packed {
        logic [7:0] sample;
        logic       last;
    } sample_exp_t;

    sample_exp_t exp_samples[$];
    logic [7:0]  level_q;
    logic [2:0]  step_q;
    mode_t       mode_q;
    int          errors = 0;

    function automatic int codes_per_byte(mode_t m);
        case (m)
            MODE_3BIT: return 3;
            MODE_2BIT: return 4;
            default:   return 2;
        endcase
    endfunction

    function automatic int up_limit(mode_t m);
        case (m)
            MODE_3BIT: return 3;
            MODE_2BIT: return 1;
            default:   return 5;
        endcase
    endfunction

    function automatic int min_step(mode_t m);
        return (m == MODE_2BIT) ? 2 : 0;
    endfunction

    task automatic decode_code_byte(input logic [7:0] b);
        int          n;
        int          lim;
        int          flo;
        int          lvl;
        int          s;
        int          mag;
        int          j;
        logic        neg;
        sample_exp_t e;
        n   = codes_per_byte(mode_q);
        lim = up_limit(mode_q);
        flo = min_step(mode_q);
        lvl = level_q;
        s   = step_q;
        for (j = 0; j < n; j++)
        begin
            case (mode_q)
                MODE_3BIT:
                begin
                    neg = b[7 - 3 * j];
                    mag = (j == 2) ? int'(b[0]) : int'((b >> (5 - 3 * j)) & 8'd3);
                end
                MODE_2BIT:
                begin
                    neg = b[7 - 2 * j];
                    mag = int'(b[6 - 2 * j]);
                end
                default:
                begin
                    neg = b[7 - 4 * j];
                    mag = int'((b >> (4 - 4 * j)) & 8'd7);
                end
            endcase
            lvl = neg ? lvl - (mag << s) : lvl + (mag << s);
            if (lvl > 255)
                lvl = 255;
            else if (lvl < 0)
                lvl = 0;
            e.sample = lvl[7:0];
            e.last   = (j == n - 1);
            exp_samples.push_back(e);
            if (mag >= lim && s < flo + 3)
                s++;
            if (mag == 0 && s > flo)
                s--;
        end
        level_q = lvl[7:0];
        step_q  = s[2:0];
    endtask

    always @(posedge clk)
    begin
        sample_exp_t e;
        if (!rst_n)
        begin
            level_q = 8'd128;
            step_q  = 3'd0;
            mode_q  = MODE_4BIT;
            exp_samples.delete();
        end
        else
        begin
            if (cfg_wr_en)
                mode_q = mode_t'(cfg_wr_data);
            if (in_valid && in_ready)
            begin
                if (in_cmd == CMD_REF)
                begin
                    level_q = in_byte;
                    step_q  = 3'(min_step(mode_q));
                end
                else
                    decode_code_byte(in_byte);
            end
            if (out_valid && out_ready)
            begin
                if (exp_samples.size() == 0)
                begin
                    $display("%0t: unexpected sample request: expected none, got sample %0d last %0b",
                             $time, out_pcm, out_last);
                    errors++;
                end
                else
                begin
                    e = exp_samples.pop_front();
                    if (out_pcm !== e.sample)
                    begin
                        $display("%0t: sample mismatch: expected %0d, got %0d",
                                 $time, e.sample, out_pcm);
                        errors++;
                    end
                    if (out_last !== e.last)
                    begin
                        $display("%0t: last mismatch: expected %0b, got %0b",
                                 $time, e.last, out_last);
                        errors++;
                    end
                end
            end
        end
        fail_count <= errors;
        pending    <= exp_samples.size();
    end

endmodule

FILE: dv/tb_creative_adpcm_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_creative_adpcm_decoder
// Drives reference and code bytes into the ADPCM decoder in every code mode,
// with directed corner bytes followed by random traffic and random stalls on
// both channels; the sample checker predicts and compares the output.
// ----------------------------------------------------------------------------
module tb_creative_adpcm_decoder;
    import cad_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [1:0] cfg_wr_data = 2'd0;
    int         fail_count;
    int         pending;
    int         cycle_count = 0;
    bit         hold_off_req = 1'b0;
    bit         tx_eager     = 1'b0;
    bit         rx_eager     = 1'b0;

    cad_in_if  byte_if ();
    cad_out_if sample_if ();

    always #1 clk = ~clk;

    creative_adpcm_decoder u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .byte_chan   (byte_if),
        .sample_chan (sample_if)
    );

    cad_sample_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (byte_if.valid),
        .in_ready    (byte_if.ready),
        .in_cmd      (byte_if.cmd),
        .in_byte     (byte_if.data_byte),
        .out_valid   (sample_if.valid),
        .out_ready   (sample_if.ready),
        .out_pcm     (sample_if.sample),
        .out_last    (sample_if.last),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int pick_gap(bit eager);
        int r;
        if (eager)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] pick_level();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'd0;
        if (r == 1)
            return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_byte(input logic c, input logic [7:0] b);
        int gap;
        gap = pick_gap(tx_eager);
        if (gap > 0)
        begin
            byte_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_if.valid     <= 1'b1;
        byte_if.cmd       <= c;
        byte_if.data_byte <= b;
        do
            @(posedge clk);
        while (!byte_if.ready);
    endtask

    task automatic drain();
        byte_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_mode(input mode_t m);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic run_random(input int n_items, input bit ref_first);
        int k;
        if (ref_first)
            send_byte(CMD_REF, pick_level());
        for (k = 0; k < n_items; k++)
        begin
            if ($urandom_range(0, 99) < 12)
                send_byte(CMD_REF, pick_level());
            else
                send_byte(CMD_CODE, 8'($urandom_range(0, 255)));
        end
    endtask

    // sample sink: random ready, one long hold-off on request
    initial
    begin
        int run;
        int gap;
        sample_if.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                sample_if.ready <= 1'b0;
                repeat (80) @(posedge clk);
            end
            else
            begin
                run = rx_eager ? 8 : $urandom_range(1, 12);
                sample_if.ready <= 1'b1;
                repeat (run) @(posedge clk);
                gap = pick_gap(rx_eager);
                if (gap > 0)
                begin
                    sample_if.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        mode_t phase_modes[8];
        int    p;
        phase_modes = '{MODE_4BIT, MODE_3BIT, MODE_2BIT, MODE_RSVD,
                        MODE_2BIT, MODE_4BIT, MODE_3BIT, MODE_2BIT};
        byte_if.valid     = 1'b0;
        byte_if.cmd       = CMD_REF;
        byte_if.data_byte = 8'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset mode, no reference yet
        send_byte(CMD_CODE, 8'h00);
        send_byte(CMD_CODE, 8'h77);
        send_byte(CMD_CODE, 8'h77);
        send_byte(CMD_CODE, 8'hFF);
        send_byte(CMD_CODE, 8'h88);
        send_byte(CMD_REF,  8'd250);
        send_byte(CMD_CODE, 8'h77);
        send_byte(CMD_REF,  8'd3);
        send_byte(CMD_CODE, 8'hFF);
        drain();

        // step starts at the 2-bit floor
        write_mode(MODE_2BIT);
        send_byte(CMD_CODE, 8'h55);
        send_byte(CMD_REF,  8'd128);
        send_byte(CMD_CODE, 8'hFF);
        send_byte(CMD_CODE, 8'h55);
        send_byte(CMD_CODE, 8'h55);
        send_byte(CMD_CODE, 8'hAA);
        drain();

        // step carried in below the 3-bit ceiling
        write_mode(MODE_3BIT);
        send_byte(CMD_CODE, 8'h6D);
        send_byte(CMD_CODE, 8'h00);
        send_byte(CMD_CODE, 8'h00);
        send_byte(CMD_CODE, 8'hFF);
        drain();

        write_mode(MODE_RSVD);
        send_byte(CMD_CODE, 8'hF7);
        send_byte(CMD_REF,  8'd0);
        send_byte(CMD_CODE, 8'h77);
        drain();

        for (p = 0; p < 8; p++)
        begin
            write_mode(phase_modes[p]);
            tx_eager = (p == 3) || (p == 5);
            rx_eager = (p == 5);
            // start sending once the sink has begun its hold-off
            if (p == 3)
            begin
                hold_off_req = 1'b1;
                wait (!hold_off_req);
            end
            if (p == 6)
            begin
                run_random(15, 1'b1);
                drain();
                run_random(15, 1'b0);
            end
            else
                run_random(30, (p % 3) != 1);
            drain();
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: filelist.f
design/cad_pkg.sv
design/cad_in_if.sv
design/cad_out_if.sv
design/creative_adpcm_decoder.sv
dv/cad_sample_checker.sv
dv/tb_creative_adpcm_decoder.sv
